// ----- rtl/dnsqp_pkg.sv -----
package dnsqp_pkg;

	// result kinds
	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// verdict codes
	localparam logic [1:0] VERDICT_OK        = 2'd0;
	localparam logic [1:0] VERDICT_NOT_QUERY = 2'd1;
	localparam logic [1:0] VERDICT_BAD_NAME  = 2'd2;

	// frame offsets of the fields that get checked or captured
	localparam logic [15:0] ETH_TYPE_POS   = 16'd13;
	localparam logic [15:0] IP_PROTO_POS   = 16'd23;
	localparam logic [15:0] UDP_DPORT_POS  = 16'd37;
	localparam logic [15:0] TXN_ID_POS     = 16'd43;
	localparam logic [15:0] DNS_FLAGS_POS  = 16'd44;
	localparam logic [15:0] QUESTION_START = 16'd54;
	localparam logic [15:0] POS_MAX        = 16'hFFFF;

	localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;
	localparam logic [15:0] DNS_PORT_DEFAULT = 16'd53;

	// type and class bytes after the name terminator
	localparam logic [2:0] TAIL_BYTES = 3'd4;
	localparam logic [8:0] QUERY_OVERHEAD = 9'd5;

	// output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam logic [FIFO_AW:0] FIFO_ROOM_NEEDED = 3'd2;

	typedef struct packed {
		logic        kind;
		logic [7:0]  name_char;
		logic [7:0]  name_pos;
		logic [1:0]  verdict;
		logic [8:0]  question_len;
		logic [15:0] rec_type;
		logic [15:0] record_class;
		logic [15:0] query_id;
		logic        end_of_frame;
	} res_t;

	// results produced by one frame byte, in order
	typedef struct packed {
		logic [1:0] n;
		res_t       first;
		res_t       second;
	} push_t;

endpackage

// ----- rtl/dnsqp_in_if.sv -----
interface dnsqp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

// ----- rtl/dnsqp_out_if.sv -----
interface dnsqp_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  name_char;
	logic [7:0]  name_pos;
	logic [1:0]  verdict;
	logic [8:0]  question_len;
	logic [15:0] rec_type;
	logic [15:0] record_class;
	logic [15:0] query_id;
	logic        end_of_frame;

	modport source (
		output valid, output kind, output name_char, output name_pos, output verdict,
		output question_len, output rec_type, output record_class,
		output query_id, output end_of_frame, input ready
	);
	modport sink (
		input valid, input kind, input name_char, input name_pos, input verdict,
		input question_len, input rec_type, input record_class,
		input query_id, input end_of_frame, output ready
	);
endinterface

// ----- rtl/dnsqp_parse.sv -----
module dnsqp_parse #(
	parameter int NAME_LIMIT = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [7:0]        data_s1,
	input  logic              last_s1,
	input  logic [15:0]       dns_port,
	output dnsqp_pkg::push_t  push
);
	import dnsqp_pkg::*;

	localparam logic [8:0] LIMIT = 9'(NAME_LIMIT);

	logic [15:0] pos_q, pos_n;
	logic        failed_q, failed_n;
	logic [7:0]  prev_q;
	logic [8:0]  count_q, count_n;
	logic        done_q, done_n;
	logic [2:0]  tail_q, tail_n;
	logic [31:0] tc_q, tc_n;
	logic [15:0] txn_q, txn_n;
	logic [15:0] hdr16;
	logic        name_hit;
	res_t        name_res, verdict_res;

	always_comb begin
		hdr16 = {prev_q, data_s1};
		failed_n = failed_q
			| ((pos_q == ETH_TYPE_POS) && (hdr16 != ETHERTYPE_IPV4))
			| ((pos_q == IP_PROTO_POS) && (data_s1 != IP_PROTO_UDP))
			| ((pos_q == UDP_DPORT_POS) && (hdr16 != dns_port))
			| ((pos_q == DNS_FLAGS_POS) && (data_s1[7:3] != 5'd0));
		txn_n = (pos_q == TXN_ID_POS) ? hdr16 : txn_q;

		name_hit = 1'b0;
		count_n  = count_q;
		done_n   = done_q;
		tail_n   = tail_q;
		tc_n     = tc_q;
		if ((pos_q >= QUESTION_START) && !failed_n) begin
			if (!done_q) begin
				if (data_s1 == 8'd0) begin
					done_n = 1'b1;
				end else begin
					name_hit = 1'b1;
					count_n  = count_q + 9'd1;
					if (count_n >= LIMIT) begin
						done_n = 1'b1;
					end
				end
			end else if ((count_q < LIMIT) && (tail_q < TAIL_BYTES)) begin
				tc_n   = {tc_q[23:0], data_s1};
				tail_n = tail_q + 3'd1;
			end
		end

		pos_n = (pos_q != POS_MAX) ? pos_q + 16'd1 : pos_q;

		name_res           = '0;
		name_res.kind      = KIND_NAME;
		name_res.name_char = data_s1;
		name_res.name_pos  = count_q[7:0];

		verdict_res              = '0;
		verdict_res.kind         = KIND_VERDICT;
		verdict_res.end_of_frame = 1'b1;
		if (failed_n || (pos_q < QUESTION_START - 16'd1)) begin
			verdict_res.verdict = VERDICT_NOT_QUERY;
		end else if (!done_n || (count_n >= LIMIT)) begin
			verdict_res.verdict  = VERDICT_BAD_NAME;
			verdict_res.query_id = txn_n;
		end else begin
			verdict_res.verdict      = VERDICT_OK;
			verdict_res.question_len = count_n + QUERY_OVERHEAD;
			verdict_res.query_id     = txn_n;
			if (tail_n == TAIL_BYTES) begin
				verdict_res.rec_type     = tc_n[31:16];
				verdict_res.record_class = tc_n[15:0];
			end
		end

		push = '0;
		if (valid_s1) begin
			if (name_hit) begin
				push.first = name_res;
				if (last_s1) begin
					push.second = verdict_res;
					push.n      = 2'd2;
				end else begin
					push.n = 2'd1;
				end
			end else if (last_s1) begin
				push.first = verdict_res;
				push.n     = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			failed_q <= 1'b0;
			prev_q   <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			tail_q   <= '0;
			tc_q     <= '0;
			txn_q    <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				pos_q    <= '0;
				failed_q <= 1'b0;
				prev_q   <= '0;
				count_q  <= '0;
				done_q   <= 1'b0;
				tail_q   <= '0;
				tc_q     <= '0;
				txn_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				failed_q <= failed_n;
				prev_q   <= data_s1;
				count_q  <= count_n;
				done_q   <= done_n;
				tail_q   <= tail_n;
				tc_q     <= tc_n;
				txn_q    <= txn_n;
			end
		end
	end

endmodule

// ----- rtl/dnsqp_fifo.sv -----
module dnsqp_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dnsqp_pkg::push_t                  push,
	input  logic                              pop_ready,
	output logic                              head_valid,
	output dnsqp_pkg::res_t                   head,
	output logic [dnsqp_pkg::FIFO_AW:0]       level
);
	import dnsqp_pkg::*;

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   level_q;
	logic               pop;

	assign head_valid = (level_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign level      = level_q;
	assign pop        = head_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_AW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			level_q <= level_q + (FIFO_AW + 1)'(push.n) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

// ----- rtl/dns_query_frame_parser_core.sv -----
// dns query frame parser
// frame: one ethernet frame byte per transaction (frame_byte, frame_last on the
//   final byte); valid/ready handshake, a byte may be taken every cycle
// result: name byte transactions (kind 0) for each question name byte, then one
//   verdict transaction (kind 1, end_of_frame 1) per frame
// dns_port_we / dns_port_wdata: write the udp destination port, change it only
//   while no frame is in flight
// latency: a byte taken at edge k is parsed during the next cycle and its
//   results are offered on result from the cycle after edge k+1
// throughput: one byte per cycle; a byte that ends the name and the frame at
//   once makes two results, which drain from a four-entry result queue
// reset: parse state cleared, queue emptied, dns_port back to 53
// a stalled result channel fills the queue; frame.ready drops while the queue
//   cannot take the two results a byte may cause, so nothing is lost
module dns_query_frame_parser_core #(
	parameter int NAME_LIMIT = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	dnsqp_in_if.sink    frame,
	dnsqp_out_if.source result,
	input  logic        dns_port_we,
	input  logic [15:0] dns_port_wdata
);
	import dnsqp_pkg::*;

	// configured query port
	logic [15:0] dns_port_q;

	// input register stage
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	push_t             push;
	res_t              head;
	logic              head_valid;
	logic [FIFO_AW:0]  level;
	logic [FIFO_AW:0]  committed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_port_q <= DNS_PORT_DEFAULT;
		end else if (dns_port_we) begin
			dns_port_q <= dns_port_wdata;
		end
	end

	// entries held plus those the byte in stage one writes this cycle;
	// a new byte needs room for two more next cycle
	assign committed   = level + (FIFO_AW + 1)'(push.n);
	assign frame.ready = (committed <= (FIFO_AW + 1)'(FIFO_DEPTH) - FIFO_ROOM_NEEDED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= frame.valid && frame.ready;
		end
	end

	// payload of stage one needs no reset
	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			data_s1 <= frame.frame_byte;
			last_s1 <= frame.frame_last;
		end
	end

	// field checks, name extraction and verdict for the byte in stage one
	dnsqp_parse #(
		.NAME_LIMIT(NAME_LIMIT)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.last_s1  (last_s1),
		.dns_port (dns_port_q),
		.push     (push)
	);

	// result queue, decouples a stalled receiver from the byte stream
	dnsqp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop_ready  (result.ready),
		.head_valid (head_valid),
		.head       (head),
		.level      (level)
	);

	assign result.valid        = head_valid;
	assign result.kind         = head.kind;
	assign result.name_char    = head.name_char;
	assign result.name_pos     = head.name_pos;
	assign result.verdict      = head.verdict;
	assign result.question_len = head.question_len;
	assign result.rec_type     = head.rec_type;
	assign result.record_class = head.record_class;
	assign result.query_id     = head.query_id;
	assign result.end_of_frame = head.end_of_frame;

endmodule

// ----- dv/tb_dns_query_frame_parser_core.sv -----
module tb_dns_query_frame_parser_core;
	import dnsqp_pkg::*;

	// name limit, also handed to the block under test
	localparam int NAME_LIMIT = 255;
	localparam logic [8:0] LIMIT9 = 9'(NAME_LIMIT);
	// cycles to let the parser pipeline and result queue settle
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_CAP = 100;
	// least number of frame bytes queued per random phase
	localparam int PHASE_BYTES = 100;

	// one frame byte waiting to be sent; drain holds it until all results are back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       drain;
	} wire_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic dns_port_we = 1'b0;
	logic [15:0] dns_port_wdata = '0;

	// frame and result side drive, known from time zero
	logic       send_valid = 1'b0;
	logic [7:0] send_byte = '0;
	logic       send_last = 1'b0;
	logic       take_ready = 1'b0;

	dnsqp_in_if  frame_if ();
	dnsqp_out_if result_if ();

	assign frame_if.valid      = send_valid;
	assign frame_if.frame_byte = send_byte;
	assign frame_if.frame_last = send_last;
	assign result_if.ready     = take_ready;

	dns_query_frame_parser_core #(
		.NAME_LIMIT(NAME_LIMIT)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame         (frame_if),
		.result        (result_if),
		.dns_port_we   (dns_port_we),
		.dns_port_wdata(dns_port_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state, cleared at every frame end
	logic [15:0] port_cfg = DNS_PORT_DEFAULT;
	logic [15:0] byte_pos;
	logic        not_query;
	logic [31:0] hdr_window;
	logic [8:0]  name_len;
	logic        name_closed;
	logic [2:0]  tail_len;
	logic [31:0] tail_window;
	logic [15:0] txn_id;

	res_t       awaited_results[$];
	wire_byte_t frame_bytes_q[$];
	logic [7:0] frame_buf[$];
	int         mismatches = 0;

	task automatic clear_parse();
		byte_pos    = '0;
		not_query   = 1'b0;
		hdr_window  = '0;
		name_len    = '0;
		name_closed = 1'b0;
		tail_len    = '0;
		tail_window = '0;
		txn_id      = '0;
	endtask

	// advance the parser model by one accepted frame byte, queue what it yields
	task automatic parse_frame_byte(input logic [7:0] b, input logic last);
		res_t        r;
		logic [15:0] p;
		p = byte_pos;
		hdr_window = {hdr_window[23:0], b};

		// header filters, each tested on the byte that completes its field
		if (p == ETH_TYPE_POS && hdr_window[15:0] != ETHERTYPE_IPV4)
			not_query = 1'b1;
		if (p == IP_PROTO_POS && b != IP_PROTO_UDP)
			not_query = 1'b1;
		if (p == UDP_DPORT_POS && hdr_window[15:0] != port_cfg)
			not_query = 1'b1;
		if (p == TXN_ID_POS)
			txn_id = hdr_window[15:0];
		// qr and opcode must both be zero
		if (p == DNS_FLAGS_POS && b[7:3] != 5'd0)
			not_query = 1'b1;

		if (p >= QUESTION_START && !not_query) begin
			if (!name_closed) begin
				if (b == 8'd0) begin
					name_closed = 1'b1;
				end else begin
					r = '0;
					r.kind      = KIND_NAME;
					r.name_char = b;
					r.name_pos  = name_len[7:0];
					awaited_results.push_back(r);
					name_len++;
					if (name_len >= LIMIT9)
						name_closed = 1'b1;
				end
			end else if (name_len < LIMIT9 && tail_len < TAIL_BYTES) begin
				// type and class bytes after the terminator, later ones ignored
				tail_window = {tail_window[23:0], b};
				tail_len++;
			end
		end

		// position saturates on very long frames
		if (byte_pos != POS_MAX)
			byte_pos++;

		if (last) begin
			r = '0;
			r.kind         = KIND_VERDICT;
			r.end_of_frame = 1'b1;
			if (not_query || p < QUESTION_START - 16'd1) begin
				r.verdict = VERDICT_NOT_QUERY;
			end else if (!name_closed || name_len >= LIMIT9) begin
				r.verdict  = VERDICT_BAD_NAME;
				r.query_id = txn_id;
			end else begin
				r.verdict      = VERDICT_OK;
				r.question_len = name_len + QUERY_OVERHEAD;
				r.query_id     = txn_id;
				// type and class only when all four bytes made it
				if (tail_len == TAIL_BYTES) begin
					r.rec_type     = tail_window[31:16];
					r.record_class = tail_window[15:0];
				end
			end
			awaited_results.push_back(r);
			clear_parse();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// idle length: mostly none or short, a few long, with occasional busy runs
	function automatic int pick_gap(inout int run_left);
		int r;
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			run_left = $urandom_range(20, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// frame driver: one byte per transaction, random gaps between bytes
	int send_gap;
	int send_run;
	always @(posedge clk or negedge arst_n) begin : frame_driver
		wire_byte_t nxt;
		if (!arst_n) begin
			send_valid <= 1'b0;
			send_byte  <= '0;
			send_last  <= 1'b0;
			send_gap = 0;
			send_run = 0;
		end else begin
			// transaction accepted: feed the parser model
			if (send_valid && frame_if.ready)
				parse_frame_byte(send_byte, send_last);
			if (!send_valid || frame_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					send_valid <= 1'b0;
				end else if (frame_bytes_q.size() == 0 ||
						(frame_bytes_q[0].drain && awaited_results.size() != 0)) begin
					// nothing to send, or holding off until all results are back
					send_valid <= 1'b0;
				end else begin
					nxt = frame_bytes_q.pop_front();
					send_valid <= 1'b1;
					send_byte  <= nxt.data;
					send_last  <= nxt.last;
					send_gap = pick_gap(send_run);
				end
			end
		end
	end

	// result monitor: random back-pressure, in-order compare against the model
	int stall_left;
	int stall_run;
	always @(posedge clk or negedge arst_n) begin : result_monitor
		res_t seen;
		res_t want;
		if (!arst_n) begin
			take_ready <= 1'b0;
			stall_left = 0;
			stall_run  = 0;
		end else begin
			if (result_if.valid && take_ready) begin
				seen = {result_if.kind, result_if.name_char, result_if.name_pos,
					result_if.verdict, result_if.question_len, result_if.rec_type,
					result_if.record_class, result_if.query_id,
					result_if.end_of_frame};
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing awaited, kind", 32'(seen.kind), '0);
				end else begin
					want = awaited_results.pop_front();
					if (seen.kind !== want.kind)
						report_mismatch("kind", 32'(seen.kind), 32'(want.kind));
					if (seen.name_char !== want.name_char)
						report_mismatch("name_char", 32'(seen.name_char),
							32'(want.name_char));
					if (seen.name_pos !== want.name_pos)
						report_mismatch("name_pos", 32'(seen.name_pos), 32'(want.name_pos));
					if (seen.verdict !== want.verdict)
						report_mismatch("verdict", 32'(seen.verdict), 32'(want.verdict));
					if (seen.question_len !== want.question_len)
						report_mismatch("question_len", 32'(seen.question_len),
							32'(want.question_len));
					if (seen.rec_type !== want.rec_type)
						report_mismatch("rec_type", 32'(seen.rec_type), 32'(want.rec_type));
					if (seen.record_class !== want.record_class)
						report_mismatch("record_class", 32'(seen.record_class),
							32'(want.record_class));
					if (seen.query_id !== want.query_id)
						report_mismatch("query_id", 32'(seen.query_id), 32'(want.query_id));
					if (seen.end_of_frame !== want.end_of_frame)
						report_mismatch("end_of_frame", 32'(seen.end_of_frame),
							32'(want.end_of_frame));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				take_ready <= 1'b0;
			end else begin
				take_ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall_left = pick_gap(stall_run);
			end
		end
	end

	// well-formed ipv4/udp/dns query into frame_buf
	// name of nlen non-zero bytes laid out as labels, then optional terminator,
	// tail type/class bytes and extra trailing bytes
	task automatic build_query(input logic [15:0] port, input int nlen, input bit terminated,
			input int tail, input int extra);
		int left;
		int lab;
		frame_buf.delete();
		repeat (12) frame_buf.push_back(8'($urandom_range(0, 255)));  // macs
		frame_buf.push_back(ETHERTYPE_IPV4[15:8]);
		frame_buf.push_back(ETHERTYPE_IPV4[7:0]);
		frame_buf.push_back(8'h45);                                    // version, ihl
		repeat (8) frame_buf.push_back(8'($urandom_range(0, 255)));
		frame_buf.push_back(IP_PROTO_UDP);
		repeat (10) frame_buf.push_back(8'($urandom_range(0, 255)));  // checksum, addresses
		repeat (2) frame_buf.push_back(8'($urandom_range(0, 255)));   // udp source port
		frame_buf.push_back(port[15:8]);
		frame_buf.push_back(port[7:0]);
		repeat (4) frame_buf.push_back(8'($urandom_range(0, 255)));   // udp length, checksum
		repeat (2) frame_buf.push_back(8'($urandom_range(0, 255)));   // query id
		frame_buf.push_back(8'($urandom_range(0, 7)));                // qr 0, opcode 0
		repeat (9) frame_buf.push_back(8'($urandom_range(0, 255)));   // rest of dns header
		left = nlen;
		while (left > 0) begin
			lab = (left == 1) ? 0 : $urandom_range(1, (left - 1 < 63) ? left - 1 : 63);
			if (lab == 0) begin
				frame_buf.push_back(8'($urandom_range(1, 255)));
				left--;
			end else begin
				frame_buf.push_back(8'(lab));
				repeat (lab) frame_buf.push_back(8'($urandom_range(1, 255)));
				left -= lab + 1;
			end
		end
		if (terminated)
			frame_buf.push_back(8'd0);
		repeat (tail + extra) frame_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// move frame_buf to the send queue, last flag on the final byte
	task automatic send_frame(input bit drain_first);
		wire_byte_t item;
		foreach (frame_buf[i]) begin
			item.data  = frame_buf[i];
			item.last  = (i == frame_buf.size() - 1);
			item.drain = (i == 0 && drain_first) || ($urandom_range(0, 299) == 0);
			frame_bytes_q.push_back(item);
		end
	endtask

	// mostly good queries, some with a broken header, cut short, or pure noise
	task automatic random_frame();
		int pick;
		int nlen;
		int cut;
		pick = $urandom_range(0, 99);
		nlen = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 260) : $urandom_range(0, 30);
		build_query(port_cfg, nlen, $urandom_range(0, 9) != 0,
			($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 3),
			($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
		if (pick >= 90) begin
			frame_buf.delete();
			repeat ($urandom_range(1, 80)) frame_buf.push_back(8'($urandom_range(0, 255)));
		end else if (pick >= 80) begin
			cut = $urandom_range(1, 60);
			while (frame_buf.size() > cut)
				void'(frame_buf.pop_back());
		end else if (pick >= 65) begin
			case ($urandom_range(0, 3))
				0: frame_buf[ETH_TYPE_POS - 1 + $urandom_range(0, 1)] ^=
					8'(1 << $urandom_range(0, 7));
				1: frame_buf[IP_PROTO_POS] ^= 8'(1 << $urandom_range(0, 7));
				2: frame_buf[UDP_DPORT_POS - 1 + $urandom_range(0, 1)] ^=
					8'(1 << $urandom_range(0, 7));
				default: frame_buf[DNS_FLAGS_POS] |= 8'(1 << $urandom_range(3, 7));
			endcase
		end
	endtask

	// everything sent, accepted and answered, then a settle wait
	task automatic wait_quiet();
		@(negedge clk);
		while (frame_bytes_q.size() != 0 || send_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// port change only between frames with the block idle
	task automatic write_port(input logic [15:0] value);
		wait_quiet();
		@(posedge clk);
		dns_port_we    <= 1'b1;
		dns_port_wdata <= value;
		@(posedge clk);
		dns_port_we <= 1'b0;
		port_cfg = value;
	endtask

	initial begin : stimulus
		int          queued;
		logic [15:0] phase_ports[3];
		clear_parse();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames, reset port value

		// plain query, query id all ones, pausing until idle first
		build_query(port_cfg, 16, 1'b1, 4, 0);
		frame_buf[TXN_ID_POS - 1] = 8'hFF;
		frame_buf[TXN_ID_POS]     = 8'hFF;
		send_frame(1'b1);
		// query id zero, type and class all ones
		build_query(port_cfg, 5, 1'b1, 4, 0);
		frame_buf[TXN_ID_POS - 1] = 8'h00;
		frame_buf[TXN_ID_POS]     = 8'h00;
		for (int i = 1; i <= 4; i++)
			frame_buf[frame_buf.size() - i] = 8'hFF;
		send_frame(1'b0);
		// one-byte frame
		frame_buf.delete();
		frame_buf.push_back(8'hFF);
		send_frame(1'b0);
		// frame ends one byte short of the full dns header
		build_query(port_cfg, 0, 1'b0, 0, 0);
		void'(frame_buf.pop_back());
		send_frame(1'b0);
		// frame ends right after the dns header: empty name
		build_query(port_cfg, 0, 1'b0, 0, 0);
		send_frame(1'b0);
		// root name, terminator straight after the header
		build_query(port_cfg, 0, 1'b1, 4, 0);
		send_frame(1'b0);
		// terminator is the last byte
		build_query(port_cfg, 8, 1'b1, 0, 0);
		send_frame(1'b0);
		// type and class cut short
		build_query(port_cfg, 8, 1'b1, 2, 0);
		send_frame(1'b0);
		build_query(port_cfg, 9, 1'b1, 3, 0);
		send_frame(1'b0);
		// trailing bytes after type and class
		build_query(port_cfg, 8, 1'b1, 4, 20);
		send_frame(1'b0);
		// longest name that still fits
		build_query(port_cfg, NAME_LIMIT - 1, 1'b1, 4, 0);
		send_frame(1'b1);
		// name hits the limit, terminator and tail after it ignored
		build_query(port_cfg, NAME_LIMIT, 1'b1, 4, 3);
		send_frame(1'b0);
		build_query(port_cfg, NAME_LIMIT + 3, 1'b0, 0, 0);
		send_frame(1'b0);
		// name runs into the frame end
		build_query(port_cfg, 12, 1'b0, 0, 0);
		send_frame(1'b0);
		// header filters: arp ethertype, tcp, wrong port, response, non-zero opcode
		build_query(port_cfg, 6, 1'b1, 4, 0);
		frame_buf[ETH_TYPE_POS] = 8'h06;
		send_frame(1'b0);
		build_query(port_cfg, 6, 1'b1, 4, 0);
		frame_buf[IP_PROTO_POS] = 8'd6;
		send_frame(1'b0);
		build_query(port_cfg ^ 16'd1, 6, 1'b1, 4, 0);
		send_frame(1'b0);
		build_query(port_cfg, 6, 1'b1, 4, 0);
		frame_buf[DNS_FLAGS_POS] = 8'h80;
		send_frame(1'b0);
		build_query(port_cfg, 6, 1'b1, 4, 0);
		frame_buf[DNS_FLAGS_POS] = 8'h08;
		send_frame(1'b0);
		// good query after the rejects, so filter state must have cleared
		build_query(port_cfg, 10, 1'b1, 4, 0);
		send_frame(1'b0);

		// random phases at the port extremes and one random port
		phase_ports = '{16'hFFFF, 16'h0000, 16'($urandom_range(0, 65535))};
		foreach (phase_ports[k]) begin
			write_port(phase_ports[k]);
			queued = 0;
			while (queued < PHASE_BYTES) begin
				random_frame();
				queued += frame_buf.size();
				send_frame($urandom_range(0, 9) == 0);
			end
		end

		wait_quiet();
		if (mismatches == 0)
			$display("dns_query_frame_parser_core verification clean");
		else
			$display("dns_query_frame_parser_core verification failed");
		$finish;
	end

	// hang guard, well past the slowest legal run
	initial begin : watchdog
		#30_000_000;
		$display("dns_query_frame_parser_core verification failed");
		$finish;
	end

endmodule
